// ===== design/tce_pkg.sv =====
package tce_pkg;

    localparam int POSITION_BITS_DEF = 18;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [1:0] KIND_VERSION   = 2'd0;
    localparam logic [1:0] KIND_CIPHER    = 2'd1;
    localparam logic [1:0] KIND_EXTENSION = 2'd2;
    localparam logic [1:0] KIND_STATUS    = 2'd3;

    localparam logic [3:0] ST_SUCCESS       = 4'd0;
    localparam logic [3:0] ST_SHORT_INPUT   = 4'd1;
    localparam logic [3:0] ST_NOT_HANDSHAKE = 4'd2;
    localparam logic [3:0] ST_TRUNCATED     = 4'd3;
    localparam logic [3:0] ST_BAD_HS_HEADER = 4'd4;
    localparam logic [3:0] ST_NOT_CLIENT_HI = 4'd5;
    localparam logic [3:0] ST_BAD_VERSION   = 4'd6;
    localparam logic [3:0] ST_BAD_RANDOM    = 4'd7;
    localparam logic [3:0] ST_BAD_SESSION   = 4'd8;
    localparam logic [3:0] ST_BAD_CIPHERS   = 4'd9;
    localparam logic [3:0] ST_BAD_COMPRESS  = 4'd10;
    localparam logic [3:0] ST_BAD_EXT_LEN   = 4'd11;
    localparam logic [3:0] ST_BAD_EXTENSION = 4'd12;

    localparam logic [7:0] CONTENT_HANDSHAKE = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO   = 8'h01;
    localparam logic [15:0] RANDOM_BYTES     = 16'd32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        eor;
    } token_t;

    typedef struct packed {
        logic [1:0] cnt;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

// ===== design/tls_client_hello_field_extractor_top.sv =====
// Each accepted byte is parsed in the cycle it is accepted; its words appear on the
// result channel from the next cycle on, from a four-entry queue, one word per cycle
// while m_ready is high. Throughput is one byte per cycle; a byte that yields a token
// and a final status holds two queue entries, and s_ready drops while fewer than two
// entries are free. Reset (aresetn low, synchronous) empties the queue and returns the
// parser to the start of a record; no clearing pass follows.
module tls_client_hello_field_extractor_top #(
    parameter int POSITION_BITS = tce_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [15:0] m_token_value,
    output logic        m_end_of_record
);

    tce_pkg::push_t  push;
    tce_pkg::token_t out_word;
    logic            in_accept;

    assign in_accept = s_valid && s_ready;

    tce_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .byte_value (s_byte_value),
        .last_byte  (s_last_byte),
        .push       (push)
    );

    tce_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_token_kind    = out_word.kind;
    assign m_token_value   = out_word.value;
    assign m_end_of_record = out_word.eor;

endmodule

// ===== design/tce_parser.sv =====
module tce_parser #(
    parameter int POSITION_BITS = tce_pkg::POSITION_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      byte_value,
    input  logic            last_byte,
    output tce_pkg::push_t  push
);

    localparam logic [4:0] PH_HDR_TYPE = 5'd0;
    localparam logic [4:0] PH_HDR_VER  = 5'd1;
    localparam logic [4:0] PH_HDR_LEN  = 5'd2;
    localparam logic [4:0] PH_HS_TYPE  = 5'd3;
    localparam logic [4:0] PH_HS_LEN   = 5'd4;
    localparam logic [4:0] PH_CVER     = 5'd5;
    localparam logic [4:0] PH_RANDOM   = 5'd6;
    localparam logic [4:0] PH_SID_LEN  = 5'd7;
    localparam logic [4:0] PH_SID      = 5'd8;
    localparam logic [4:0] PH_CS_LEN   = 5'd9;
    localparam logic [4:0] PH_CS_HI    = 5'd10;
    localparam logic [4:0] PH_CS_LO    = 5'd11;
    localparam logic [4:0] PH_COMP_LEN = 5'd12;
    localparam logic [4:0] PH_COMP     = 5'd13;
    localparam logic [4:0] PH_EXT_OPT  = 5'd14;
    localparam logic [4:0] PH_EXT_LEN  = 5'd15;
    localparam logic [4:0] PH_EXT_TYPE = 5'd16;
    localparam logic [4:0] PH_EXT_DLEN = 5'd17;
    localparam logic [4:0] PH_EXT_DATA = 5'd18;
    localparam logic [4:0] PH_DONE     = 5'd19;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [4:0]               phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              rem_reg, rem_next;
    logic [15:0]              acc_reg, acc_next;
    logic [15:0]              rlen_reg, rlen_next;
    logic [POSITION_BITS-1:0] ext_end_reg, ext_end_next;
    logic [3:0]               ferr_reg, ferr_next;
    logic                     wct_reg, wct_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS:0]   pos4_sum;
    logic [POSITION_BITS-1:0] pos4;
    logic [POSITION_BITS:0]   ext_sum;
    logic [POSITION_BITS-1:0] ext_end_calc;
    logic [15:0]              acc_shift;
    logic [15:0]              rem_dec;
    logic [16:0]              rlen5;
    logic                     tok_valid;
    tce_pkg::token_t          tok;
    tce_pkg::token_t          status_tok;
    logic [3:0]               status;

    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign pos4_sum  = {1'b0, pos_inc} + (POSITION_BITS + 1)'(4);
    assign pos4      = pos4_sum[POSITION_BITS] ? POS_MAX : pos4_sum[POSITION_BITS-1:0];
    assign acc_shift = {acc_reg[7:0], byte_value};
    assign rem_dec   = rem_reg - 16'd1;
    assign ext_sum   = {1'b0, pos_inc} + (POSITION_BITS + 1)'(acc_shift);
    assign ext_end_calc = ext_sum[POSITION_BITS] ? POS_MAX : ext_sum[POSITION_BITS-1:0];

    always_comb begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        rlen_next    = rlen_reg;
        ext_end_next = ext_end_reg;
        ferr_next    = ferr_reg;
        wct_next     = wct_reg;
        tok_valid    = 1'b0;
        tok.kind     = tce_pkg::KIND_VERSION;
        tok.value    = acc_shift;
        tok.eor      = 1'b0;

        unique case (phase_reg)
            PH_HDR_TYPE: begin
                if (byte_value != tce_pkg::CONTENT_HANDSHAKE) begin
                    wct_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_HDR_VER;
                    rem_next   = 16'd2;
                    acc_next   = 16'd0;
                end
            end
            PH_HDR_VER: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    phase_next = PH_HDR_LEN;
                    rem_next   = 16'd2;
                    acc_next   = 16'd0;
                end
            end
            PH_HDR_LEN: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    rlen_next  = acc_shift;
                    phase_next = PH_HS_TYPE;
                end
            end
            PH_HS_TYPE: begin
                acc_next   = {8'd0, byte_value};
                rem_next   = 16'd3;
                phase_next = PH_HS_LEN;
            end
            PH_HS_LEN: begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (acc_reg != {8'd0, tce_pkg::HS_CLIENT_HELLO}) begin
                        ferr_next  = tce_pkg::ST_NOT_CLIENT_HI;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_CVER;
                        rem_next   = 16'd2;
                        acc_next   = 16'd0;
                    end
                end
            end
            PH_CVER: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    tok_valid  = 1'b1;
                    tok.kind   = tce_pkg::KIND_VERSION;
                    phase_next = PH_RANDOM;
                    rem_next   = tce_pkg::RANDOM_BYTES;
                end
            end
            PH_RANDOM: begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    phase_next = PH_SID_LEN;
                end
            end
            PH_SID_LEN: begin
                if (byte_value == 8'd0) begin
                    phase_next = PH_CS_LEN;
                    rem_next   = 16'd2;
                    acc_next   = 16'd0;
                end else begin
                    phase_next = PH_SID;
                    rem_next   = {8'd0, byte_value};
                end
            end
            PH_SID: begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    phase_next = PH_CS_LEN;
                    rem_next   = 16'd2;
                    acc_next   = 16'd0;
                end
            end
            PH_CS_LEN: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (acc_shift == 16'd0) begin
                        phase_next = PH_COMP_LEN;
                    end else begin
                        phase_next = PH_CS_HI;
                        rem_next   = acc_shift;
                    end
                end
            end
            PH_CS_HI: begin
                if (rem_reg <= 16'd1) begin
                    rem_next   = 16'd0;
                    phase_next = PH_COMP_LEN;
                end else begin
                    acc_next   = {8'd0, byte_value};
                    rem_next   = rem_dec;
                    phase_next = PH_CS_LO;
                end
            end
            PH_CS_LO: begin
                tok_valid  = 1'b1;
                tok.kind   = tce_pkg::KIND_CIPHER;
                rem_next   = rem_dec;
                phase_next = (rem_dec == 16'd0) ? PH_COMP_LEN : PH_CS_HI;
            end
            PH_COMP_LEN: begin
                if (byte_value == 8'd0) begin
                    phase_next = PH_EXT_OPT;
                end else begin
                    phase_next = PH_COMP;
                    rem_next   = {8'd0, byte_value};
                end
            end
            PH_COMP: begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    phase_next = PH_EXT_OPT;
                end
            end
            PH_EXT_OPT: begin
                acc_next   = {8'd0, byte_value};
                rem_next   = 16'd1;
                phase_next = PH_EXT_LEN;
            end
            PH_EXT_LEN: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    ext_end_next = ext_end_calc;
                    if (pos4 <= ext_end_calc) begin
                        phase_next = PH_EXT_TYPE;
                        rem_next   = 16'd2;
                        acc_next   = 16'd0;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_EXT_TYPE: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    tok_valid  = 1'b1;
                    tok.kind   = tce_pkg::KIND_EXTENSION;
                    phase_next = PH_EXT_DLEN;
                    rem_next   = 16'd2;
                    acc_next   = 16'd0;
                end
            end
            PH_EXT_DLEN: begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (acc_shift != 16'd0) begin
                        phase_next = PH_EXT_DATA;
                        rem_next   = acc_shift;
                    end else if (pos4 <= ext_end_reg) begin
                        phase_next = PH_EXT_TYPE;
                        rem_next   = 16'd2;
                        acc_next   = 16'd0;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_EXT_DATA: begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (pos4 <= ext_end_reg) begin
                        phase_next = PH_EXT_TYPE;
                        rem_next   = 16'd2;
                        acc_next   = 16'd0;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign rlen5 = {1'b0, rlen_next} + 17'd5;

    always_comb begin
        if (pos_inc < POSITION_BITS'(5)) begin
            status = tce_pkg::ST_SHORT_INPUT;
        end else if (wct_next) begin
            status = tce_pkg::ST_NOT_HANDSHAKE;
        end else if ({1'b0, pos_inc} < (POSITION_BITS + 1)'(rlen5)) begin
            status = tce_pkg::ST_TRUNCATED;
        end else if (ferr_next != tce_pkg::ST_SUCCESS) begin
            status = ferr_next;
        end else begin
            case (phase_next) inside
                PH_HS_TYPE, PH_HS_LEN:              status = tce_pkg::ST_BAD_HS_HEADER;
                PH_CVER:                            status = tce_pkg::ST_BAD_VERSION;
                PH_RANDOM:                          status = tce_pkg::ST_BAD_RANDOM;
                PH_SID_LEN, PH_SID:                 status = tce_pkg::ST_BAD_SESSION;
                PH_CS_LEN, PH_CS_HI, PH_CS_LO:      status = tce_pkg::ST_BAD_CIPHERS;
                PH_COMP_LEN, PH_COMP:               status = tce_pkg::ST_BAD_COMPRESS;
                PH_EXT_LEN:                         status = tce_pkg::ST_BAD_EXT_LEN;
                PH_EXT_TYPE, PH_EXT_DLEN, PH_EXT_DATA:
                                                    status = tce_pkg::ST_BAD_EXTENSION;
                default:                            status = tce_pkg::ST_SUCCESS;
            endcase
        end
    end

    always_comb begin
        status_tok.kind  = tce_pkg::KIND_STATUS;
        status_tok.value = {12'd0, status};
        status_tok.eor   = 1'b1;
        push.second      = status_tok;
        push.first       = tok_valid ? tok : status_tok;
        if (!in_accept) begin
            push.cnt = 2'd0;
        end else begin
            push.cnt = {1'b0, tok_valid} + {1'b0, last_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR_TYPE;
            pos_reg     <= '0;
            rem_reg     <= '0;
            acc_reg     <= '0;
            rlen_reg    <= '0;
            ext_end_reg <= '0;
            ferr_reg    <= tce_pkg::ST_SUCCESS;
            wct_reg     <= 1'b0;
        end else if (in_accept) begin
            if (last_byte) begin
                phase_reg   <= PH_HDR_TYPE;
                pos_reg     <= '0;
                rem_reg     <= '0;
                acc_reg     <= '0;
                rlen_reg    <= '0;
                ext_end_reg <= '0;
                ferr_reg    <= tce_pkg::ST_SUCCESS;
                wct_reg     <= 1'b0;
            end else begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_inc;
                rem_reg     <= rem_next;
                acc_reg     <= acc_next;
                rlen_reg    <= rlen_next;
                ext_end_reg <= ext_end_next;
                ferr_reg    <= ferr_next;
                wct_reg     <= wct_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt == 2'd2) |->
            (push.second.kind == tce_pkg::KIND_STATUS &&
             push.first.kind != tce_pkg::KIND_STATUS))
        else $error("Two words pushed but not a token followed by a status.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |->
            (push.first.eor == (push.first.kind == tce_pkg::KIND_STATUS)))
        else $error("End of record mark disagrees with the token kind.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && last_byte) |=> (phase_reg == PH_HDR_TYPE && pos_reg == '0))
        else $error("Parser did not return to the record start after the last byte.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (wct_reg || ferr_reg != tce_pkg::ST_SUCCESS) |-> (phase_reg == PH_DONE))
        else $error("Parser kept walking the record after an error.");

endmodule

// ===== design/tce_fifo.sv =====
module tce_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  tce_pkg::push_t  push,
    output logic            space_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output tce_pkg::token_t out_word
);

    localparam int PW = tce_pkg::FIFO_PTR_W;

    tce_pkg::token_t mem [tce_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= (PW + 1)'(tce_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW + 1)'(push.cnt) - (PW + 1)'(pop);
        end
    end

endmodule
